// ----- design/bcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int TIME_W  = 32;
    localparam int VOLT_W  = 17;
    localparam int CURR_W  = 16;
    localparam int POWER_W = 23;
    localparam int CHG_W   = 48;
    localparam int NRG_W   = 56;
    localparam int STEP_W  = 14;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 3;
    localparam int FAULT_W = 2;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 17;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CC    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CV    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_FLOAT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_FAULT = 3'd5;

    localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_OV      = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_TIMEOUT = 2'd2;

    localparam logic [IDX_W-1:0] REG_CV_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF       = 3'd1;
    localparam logic [IDX_W-1:0] REG_OV_LIMIT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_TIME     = 3'd3;
    localparam logic [IDX_W-1:0] REG_CCCV_MODE    = 3'd4;
    localparam logic [IDX_W-1:0] REG_HAS_FLOAT    = 3'd5;
    localparam logic [IDX_W-1:0] REG_DV_THRESHOLD = 3'd6;

    localparam logic [TIME_W-1:0] STEP_LIMIT_MS = 32'd10000;
    localparam logic [TIME_W-1:0] WARMUP_MS     = 32'd60000;
    localparam logic [TIME_W-1:0] MS_PER_MIN    = 32'd60000;
    localparam logic [VOLT_W-1:0] MIN_VALID_MV  = 17'd100;

    localparam logic [VOLT_W-1:0] VOLT_ONES = {VOLT_W{1'b1}};
    localparam logic [CHG_W-1:0]  CHG_ONES  = {CHG_W{1'b1}};
    localparam logic [NRG_W-1:0]  NRG_ONES  = {NRG_W{1'b1}};

    typedef struct packed {
        logic [VOLT_W-1:0] cv_threshold_mv;
        logic [CURR_W-1:0] cutoff_current_ma;
        logic [VOLT_W-1:0] overvoltage_limit_mv;
        logic [TIME_W-1:0] timeout_ms;
        logic              cccv_mode;
        logic              has_float;
        logic [VOLT_W-1:0] dv_threshold_mv;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TIME_W-1:0]  time_ms;
        logic [VOLT_W-1:0]  voltage_mv;
        logic [CURR_W-1:0]  current_ma;
        logic [POWER_W-1:0] power_mw;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] charge_state;
        logic [FAULT_W-1:0] fault_code;
        logic               output_on;
        logic               float_setpoints;
        logic               phase_changed;
        logic [TIME_W-1:0]  elapsed_ms;
        logic [CHG_W-1:0]   charge_mams;
        logic [NRG_W-1:0]   energy_mwms;
        logic [VOLT_W-1:0]  peak_voltage_mv;
        logic [CURR_W-1:0]  peak_current_ma;
        logic [VOLT_W-1:0]  min_voltage_mv;
    } result_t;

endpackage

`default_nettype wire

// ----- design/bcc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    input  wire logic [bcc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_W-1:0] cfg_data,
    output bcc_pkg::cfg_t                 cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CV_THRESHOLD: cfg_next.cv_threshold_mv = cfg_data[VOLT_W-1:0];
                REG_CUTOFF:       cfg_next.cutoff_current_ma = cfg_data[CURR_W-1:0];
                REG_OV_LIMIT:     cfg_next.overvoltage_limit_mv = cfg_data[VOLT_W-1:0];
                REG_MAX_TIME: begin
                    // keep the limit in ms
                    cfg_next.timeout_ms = TIME_W'(cfg_data[CURR_W-1:0]) * MS_PER_MIN;
                end
                REG_CCCV_MODE:    cfg_next.cccv_mode = cfg_data[0];
                REG_HAS_FLOAT:    cfg_next.has_float = cfg_data[0];
                REG_DV_THRESHOLD: cfg_next.dv_threshold_mv = cfg_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cv_threshold_mv      <= 17'd4150;
            cfg_reg.cutoff_current_ma    <= '0;
            cfg_reg.overvoltage_limit_mv <= VOLT_ONES;
            cfg_reg.timeout_ms           <= 32'd10800000;
            cfg_reg.cccv_mode            <= 1'b1;
            cfg_reg.has_float            <= 1'b0;
            cfg_reg.dv_threshold_mv      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/bcc_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bcc_engine (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    advance,
    input  wire bcc_pkg::item_t item,
    input  wire bcc_pkg::cfg_t  cfg,
    output bcc_pkg::result_t res
);
    import bcc_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic               first_reg, first_next;
    logic               out_en_reg, out_en_next;
    logic               float_reg, float_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [CHG_W-1:0]   charge_reg, charge_next;
    logic [NRG_W-1:0]   energy_reg, energy_next;
    logic [VOLT_W-1:0]  max_volt_reg, max_volt_next;
    logic [CURR_W-1:0]  max_curr_reg, max_curr_next;
    logic [VOLT_W-1:0]  min_volt_reg, min_volt_next;
    logic [VOLT_W-1:0]  dv_peak_reg, dv_peak_next;

    logic [TIME_W-1:0]         st, lt, dt_full, run_ms;
    logic                      step_ok, run_neg, active;
    logic [STEP_W-1:0]         dt;
    logic [CURR_W+STEP_W-1:0]  prod_c;
    logic [POWER_W+STEP_W-1:0] prod_e;
    logic [CHG_W:0]            sum_c;
    logic [NRG_W:0]            sum_e;
    logic [VOLT_W-1:0]         v, dv_drop;
    logic [CURR_W-1:0]         i;
    logic [TIME_W-1:0]         t;

    assign t = item.time_ms;
    assign v = item.voltage_mv;
    assign i = item.current_ma;

    assign active  = (phase_reg == PH_CC) || (phase_reg == PH_CV) || (phase_reg == PH_FLOAT);
    assign st      = first_reg ? t : start_reg;
    assign lt      = first_reg ? t : last_reg;
    assign dt_full = t - lt;
    assign step_ok = (t > lt) && (dt_full < STEP_LIMIT_MS);
    assign dt      = dt_full[STEP_W-1:0];
    assign prod_c  = (CURR_W+STEP_W)'(i) * (CURR_W+STEP_W)'(dt);
    assign prod_e  = (POWER_W+STEP_W)'(item.power_mw) * (POWER_W+STEP_W)'(dt);
    assign sum_c   = {1'b0, charge_reg} + (CHG_W+1)'(prod_c);
    assign sum_e   = {1'b0, energy_reg} + (NRG_W+1)'(prod_e);
    assign run_neg = t < st;
    assign run_ms  = t - st;
    assign dv_drop = dv_peak_reg - v;

    always_comb begin
        phase_next    = phase_reg;
        fault_next    = fault_reg;
        first_next    = first_reg;
        out_en_next   = out_en_reg;
        float_next    = float_reg;
        start_next    = start_reg;
        last_next     = last_reg;
        charge_next   = charge_reg;
        energy_next   = energy_reg;
        max_volt_next = max_volt_reg;
        max_curr_next = max_curr_reg;
        min_volt_next = min_volt_reg;
        dv_peak_next  = dv_peak_reg;
        case (item.command)
            CMD_START: begin
                phase_next    = PH_CC;
                fault_next    = FAULT_NONE;
                first_next    = 1'b1;
                out_en_next   = 1'b1;
                float_next    = 1'b0;
                start_next    = '0;
                last_next     = '0;
                charge_next   = '0;
                energy_next   = '0;
                max_volt_next = '0;
                max_curr_next = '0;
                min_volt_next = VOLT_ONES;
                dv_peak_next  = '0;
            end
            CMD_STOP: begin
                if (phase_reg != PH_IDLE) begin
                    phase_next  = PH_IDLE;
                    fault_next  = FAULT_NONE;
                    out_en_next = 1'b0;
                end
            end
            CMD_SAMPLE: begin
                if (active) begin
                    first_next = 1'b0;
                    start_next = st;
                    last_next  = t;
                    if (step_ok) begin
                        charge_next = (sum_c >= (CHG_W+1)'(CHG_ONES)) ? CHG_ONES
                                                                       : sum_c[CHG_W-1:0];
                        energy_next = (sum_e >= (NRG_W+1)'(NRG_ONES)) ? NRG_ONES
                                                                       : sum_e[NRG_W-1:0];
                    end
                    if (v > max_volt_reg) max_volt_next = v;
                    if (i > max_curr_reg) max_curr_next = i;
                    if (v < min_volt_reg && v > MIN_VALID_MV) min_volt_next = v;
                    if (v > cfg.overvoltage_limit_mv) begin
                        phase_next  = PH_FAULT;
                        fault_next  = FAULT_OV;
                        out_en_next = 1'b0;
                    end else if (!run_neg && run_ms > cfg.timeout_ms) begin
                        phase_next  = PH_FAULT;
                        fault_next  = FAULT_TIMEOUT;
                        out_en_next = 1'b0;
                    end else if (cfg.cccv_mode) begin
                        if (phase_reg == PH_CC) begin
                            if (v >= cfg.cv_threshold_mv) phase_next = PH_CV;
                        end else if (phase_reg == PH_CV) begin
                            if (cfg.cutoff_current_ma != '0 && i <= cfg.cutoff_current_ma) begin
                                if (cfg.has_float) begin
                                    phase_next = PH_FLOAT;
                                    float_next = 1'b1;
                                end else begin
                                    phase_next  = PH_DONE;
                                    out_en_next = 1'b0;
                                end
                            end
                        end
                    end else if (phase_reg == PH_CC) begin
                        if (run_neg || run_ms < WARMUP_MS) begin
                            dv_peak_next = v;
                        end else if (v > dv_peak_reg) begin
                            dv_peak_next = v;
                        end else if (cfg.dv_threshold_mv != '0 &&
                                     dv_drop >= cfg.dv_threshold_mv) begin
                            phase_next  = PH_DONE;
                            out_en_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            fault_reg    <= FAULT_NONE;
            first_reg    <= 1'b1;
            out_en_reg   <= 1'b0;
            float_reg    <= 1'b0;
            start_reg    <= '0;
            last_reg     <= '0;
            charge_reg   <= '0;
            energy_reg   <= '0;
            max_volt_reg <= '0;
            max_curr_reg <= '0;
            min_volt_reg <= VOLT_ONES;
            dv_peak_reg  <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            fault_reg    <= fault_next;
            first_reg    <= first_next;
            out_en_reg   <= out_en_next;
            float_reg    <= float_next;
            start_reg    <= start_next;
            last_reg     <= last_next;
            charge_reg   <= charge_next;
            energy_reg   <= energy_next;
            max_volt_reg <= max_volt_next;
            max_curr_reg <= max_curr_next;
            min_volt_reg <= min_volt_next;
            dv_peak_reg  <= dv_peak_next;
        end
    end

    always_comb begin
        res.charge_state    = phase_next;
        res.fault_code      = fault_next;
        res.output_on       = out_en_next;
        res.float_setpoints = float_next;
        res.phase_changed   = (phase_next != phase_reg);
        res.elapsed_ms      = (phase_next != PH_IDLE && last_next >= start_next)
                              ? (last_next - start_next) : '0;
        res.charge_mams     = charge_next;
        res.energy_mwms     = energy_next;
        res.peak_voltage_mv = max_volt_next;
        res.peak_current_ma = max_curr_next;
        res.min_voltage_mv  = min_volt_next;
    end

endmodule

`default_nettype wire

// ----- design/battery_charge_controller_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tuser command, s_tdata sample
// m_        out        m_tvalid / m_tready   m_tdata status and statistics
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle unless m_tready stalls; m_tvalid rises when the input register advances.
// The input register feeds the charge state update, whose result is registered
// on the same edge that commits the new state.
// Synchronous active-low reset returns the sequencer to idle with reset settings.
// A stalled result holds the input register; s_tready drops only when both stages are full.

module battery_charge_controller_unit (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output      logic                     s_tready,
    // time_ms[31:0], voltage_mv[48:32], current_ma[64:49], power_mw[87:65]
    input  wire logic [87:0]              s_tdata,
    // command[1:0]
    input  wire logic [1:0]               s_tuser,
    output      logic                     m_tvalid,
    input  wire logic                     m_tready,
    // charge_state[2:0], fault_code[4:3], output_on[5], float_setpoints[6],
    // phase_changed[7], elapsed_ms[39:8], charge_mams[87:40], energy_mwms[143:88],
    // peak_voltage_mv[160:144], peak_current_ma[176:161], min_voltage_mv[193:177],
    // zero fill[199:194]
    output      logic [199:0]             m_tdata,
    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire logic [bcc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_W-1:0] cfg_data
);
    import bcc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg, item_next;
    result_t res;
    result_t res_reg;
    logic    in_vld_reg, in_vld_next;
    logic    m_vld_reg, m_vld_next;
    logic    advance, s_fire;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_fire    = s_tvalid && s_tready;

    bcc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        item_next            = item_reg;
        in_vld_next          = in_vld_reg;
        if (advance) in_vld_next = 1'b0;
        if (s_fire) begin
            item_next.command    = s_tuser;
            item_next.time_ms    = s_tdata[31:0];
            item_next.voltage_mv = s_tdata[48:32];
            item_next.current_ma = s_tdata[64:49];
            item_next.power_mw   = s_tdata[87:65];
            in_vld_next          = 1'b1;
        end
        m_vld_next = m_vld_reg;
        if (m_tready) m_vld_next = 1'b0;
        if (advance) m_vld_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (advance) res_reg <= res;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {6'd0, res_reg.min_voltage_mv, res_reg.peak_current_ma,
                       res_reg.peak_voltage_mv, res_reg.energy_mwms, res_reg.charge_mams,
                       res_reg.elapsed_ms, res_reg.phase_changed, res_reg.float_setpoints,
                       res_reg.output_on, res_reg.fault_code, res_reg.charge_state};

    a_output_on_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.output_on |->
            (res_reg.charge_state == PH_CC || res_reg.charge_state == PH_CV ||
             res_reg.charge_state == PH_FLOAT))
        else $error("output enabled outside an active charge phase");

    a_fault_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg |-> ((res_reg.fault_code != FAULT_NONE) ==
                       (res_reg.charge_state == PH_FAULT)))
        else $error("fault code disagrees with charge state");

    a_float_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && res_reg.float_setpoints |->
            (res_reg.charge_state == PH_FLOAT || res_reg.charge_state == PH_IDLE ||
             res_reg.charge_state == PH_FAULT))
        else $error("float setpoints in force in a charge phase");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled while a stage is free");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bcc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // time_ms, voltage_mv, current_ma, power_mw
    logic [87:0]         s_tdata = '0;
    // command
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready;
    // charge_state, fault_code, output_on, float_setpoints, phase_changed, elapsed_ms,
    // charge_mams, energy_mwms, peak_voltage_mv, peak_current_ma, min_voltage_mv
    logic [199:0]        m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    // settings as the block holds them
    logic [VOLT_W-1:0]   cv_thresh = 17'd4150;
    logic [CURR_W-1:0]   cutoff_ma = '0;
    logic [VOLT_W-1:0]   ov_limit = VOLT_ONES;
    logic [CURR_W-1:0]   limit_min = 16'd180;
    logic                cccv = 1'b1;
    logic                float_en = 1'b0;
    logic [VOLT_W-1:0]   dv_thresh = '0;

    // charger state
    logic [PHASE_W-1:0]  phase = PH_IDLE;
    logic [FAULT_W-1:0]  fault = FAULT_NONE;
    logic                first_sample = 1'b1;
    logic [TIME_W-1:0]   t_start = '0;
    logic [TIME_W-1:0]   t_last = '0;
    logic [CHG_W-1:0]    charge_acc = '0;
    logic [NRG_W-1:0]    energy_acc = '0;
    logic [VOLT_W-1:0]   v_max = '0;
    logic [CURR_W-1:0]   i_max = '0;
    logic [VOLT_W-1:0]   v_min = VOLT_ONES;
    logic [VOLT_W-1:0]   dv_ref = '0;
    logic                out_en = 1'b0;
    logic                float_on = 1'b0;

    result_t pending_status[$];
    int      mismatch_count = 0;
    bit      tx_gaps = 1'b1;
    bit      rx_stalls = 1'b1;
    int      hold_off_cycles = 0;
    int      home_mv = 4100;

    battery_charge_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic result_t advance_charger(input logic [CMD_W-1:0] cmd,
            input logic [TIME_W-1:0] t, input logic [VOLT_W-1:0] v,
            input logic [CURR_W-1:0] i, input logic [POWER_W-1:0] p);
        result_t            r;
        logic [PHASE_W-1:0] prior;
        logic [63:0]        dq;
        logic [63:0]        de;
        longint             run_ms;
        longint             limit_ms;
        longint             warm_ms;
        prior = phase;
        if (cmd == CMD_START) begin
            charge_acc = '0;
            energy_acc = '0;
            v_max = '0;
            i_max = '0;
            v_min = VOLT_ONES;
            dv_ref = '0;
            t_start = '0;
            t_last = '0;
            first_sample = 1'b1;
            float_on = 1'b0;
            fault = FAULT_NONE;
            out_en = 1'b1;
            phase = PH_CC;
        end else if (cmd == CMD_STOP) begin
            if (phase != PH_IDLE) begin
                out_en = 1'b0;
                phase = PH_IDLE;
                fault = FAULT_NONE;
            end
        end else if (cmd == CMD_SAMPLE &&
                     (phase == PH_CC || phase == PH_CV || phase == PH_FLOAT)) begin
            if (first_sample) begin
                t_start = t;
                t_last = t;
                first_sample = 1'b0;
            end
            if (t > t_last && t - t_last < STEP_LIMIT_MS) begin
                dq = t - t_last;
                de = dq * p;
                dq = dq * i;
                charge_acc = (dq >= CHG_ONES - charge_acc) ? CHG_ONES
                                                           : CHG_W'(charge_acc + dq);
                energy_acc = (de >= NRG_ONES - energy_acc) ? NRG_ONES
                                                           : NRG_W'(energy_acc + de);
            end
            t_last = t;
            run_ms = $signed({32'd0, t}) - $signed({32'd0, t_start});
            limit_ms = limit_min * MS_PER_MIN;
            warm_ms = WARMUP_MS;
            if (v > v_max) v_max = v;
            if (i > i_max) i_max = i;
            if (v < v_min && v > MIN_VALID_MV) v_min = v;
            if (v > ov_limit) begin
                out_en = 1'b0;
                phase = PH_FAULT;
                fault = FAULT_OV;
            end else if (run_ms > limit_ms) begin
                out_en = 1'b0;
                phase = PH_FAULT;
                fault = FAULT_TIMEOUT;
            end else if (cccv) begin
                if (phase == PH_CC) begin
                    if (v >= cv_thresh) phase = PH_CV;
                end else if (phase == PH_CV && cutoff_ma != 0 && i <= cutoff_ma) begin
                    if (float_en) begin
                        float_on = 1'b1;
                        phase = PH_FLOAT;
                    end else begin
                        out_en = 1'b0;
                        phase = PH_DONE;
                    end
                end
            end else if (phase == PH_CC) begin
                if (run_ms < warm_ms) begin
                    dv_ref = v;
                end else if (v > dv_ref) begin
                    dv_ref = v;
                end else if (dv_thresh != 0 && dv_ref - v >= dv_thresh) begin
                    out_en = 1'b0;
                    phase = PH_DONE;
                end
            end
        end
        r.charge_state = phase;
        r.fault_code = fault;
        r.output_on = out_en;
        r.float_setpoints = float_on;
        r.phase_changed = (phase != prior);
        r.elapsed_ms = (phase != PH_IDLE && t_last >= t_start) ? t_last - t_start : '0;
        r.charge_mams = charge_acc;
        r.energy_mwms = energy_acc;
        r.peak_voltage_mv = v_max;
        r.peak_current_ma = i_max;
        r.min_voltage_mv = v_min;
        return r;
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
            input logic [VOLT_W-1:0] v, input logic [CURR_W-1:0] i,
            input logic [POWER_W-1:0] p);
        int n;
        n = tx_gaps ? pick_gap() : 0;
        @(negedge aclk);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {p, i, v, t};
        do @(posedge aclk); while (!s_tready);
        pending_status.push_back(advance_charger(cmd, t, v, i, p));
    endtask

    task automatic drain_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CV_THRESHOLD: cv_thresh = val;
            REG_CUTOFF:       cutoff_ma = val[CURR_W-1:0];
            REG_OV_LIMIT:     ov_limit = val;
            REG_MAX_TIME:     limit_min = val[CURR_W-1:0];
            REG_CCCV_MODE:    cccv = val[0];
            REG_HAS_FLOAT:    float_en = val[0];
            REG_DV_THRESHOLD: dv_thresh = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int cv, input int cut, input int ov, input int mins,
            input int mode, input int flt, input int dv);
        write_reg(REG_CV_THRESHOLD, CFG_W'(cv));
        write_reg(REG_CUTOFF, CFG_W'(cut));
        write_reg(REG_OV_LIMIT, CFG_W'(ov));
        write_reg(REG_MAX_TIME, CFG_W'(mins));
        write_reg(REG_CCCV_MODE, CFG_W'(mode));
        write_reg(REG_HAS_FLOAT, CFG_W'(flt));
        write_reg(REG_DV_THRESHOLD, CFG_W'(dv));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin : receiver
        int n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                n = rx_stalls ? pick_gap() : 0;
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n - 1) @(negedge aclk);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_status.pop_front();
                check_field("charge_state", want.charge_state, m_tdata[2:0]);
                check_field("fault_code", want.fault_code, m_tdata[4:3]);
                check_field("output_on", want.output_on, m_tdata[5]);
                check_field("float_setpoints", want.float_setpoints, m_tdata[6]);
                check_field("phase_changed", want.phase_changed, m_tdata[7]);
                check_field("elapsed_ms", want.elapsed_ms, m_tdata[39:8]);
                check_field("charge_mams", want.charge_mams, m_tdata[87:40]);
                check_field("energy_mwms", want.energy_mwms, m_tdata[143:88]);
                check_field("peak_voltage_mv", want.peak_voltage_mv, m_tdata[160:144]);
                check_field("peak_current_ma", want.peak_current_ma, m_tdata[176:161]);
                check_field("min_voltage_mv", want.min_voltage_mv, m_tdata[193:177]);
            end
        end
    end

    task automatic test_idle_commands;
        send_request(CMD_SAMPLE, 32'hFFFF_FFFF, VOLT_ONES, 16'hFFFF, 23'h7F_FFFF);
        send_request(CMD_RESERVED, '0, '0, '0, '0);
        send_request(CMD_STOP, '0, '0, '0, '0);
    endtask

    task automatic test_cccv_termination;
        drain_results;
        write_reg(REG_CUTOFF, 500);
        write_reg(REG_HAS_FLOAT, 0);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 1000, 100, 0, 0);
        send_request(CMD_SAMPLE, 1001, 101, 16'hFFFF, 23'h7F_FFFF);
        send_request(CMD_SAMPLE, 11000, 4150, 16'hFFFF, 23'h7F_FFFF);
        send_request(CMD_SAMPLE, 21000, 4200, 600, 1000);
        send_request(CMD_SAMPLE, 20500, 4100, 500, 1000);
    endtask

    task automatic test_float_stage;
        drain_results;
        write_reg(REG_CUTOFF, 65535);
        write_reg(REG_HAS_FLOAT, 1);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 32'hFFFF_FFFF, 4150, 1000, 5);
        send_request(CMD_SAMPLE, 0, 4000, 16'hFFFF, 5);
        send_request(CMD_STOP, '0, '0, '0, '0);
        send_request(CMD_START, '0, '0, '0, '0);
    endtask

    task automatic test_faults;
        drain_results;
        write_reg(REG_OV_LIMIT, 5000);
        write_reg(REG_MAX_TIME, 1);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 500, 5000, 100, 100);
        send_request(CMD_SAMPLE, 600, 5001, 100, 100);
        send_request(CMD_STOP, '0, '0, '0, '0);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 0, 3000, 100, 100);
        // overvoltage wins over timeout
        send_request(CMD_SAMPLE, 70000, 6000, 100, 100);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 0, 3000, 100, 100);
        send_request(CMD_SAMPLE, 60001, 3000, 100, 100);
    endtask

    task automatic test_delta_v;
        drain_results;
        write_reg(REG_CCCV_MODE, 0);
        write_reg(REG_DV_THRESHOLD, 50);
        write_reg(REG_OV_LIMIT, VOLT_ONES);
        write_reg(REG_MAX_TIME, 65535);
        send_request(CMD_START, '0, '0, '0, '0);
        send_request(CMD_SAMPLE, 100000, 4000, 2000, 9000);
        send_request(CMD_SAMPLE, 159999, 3000, 2000, 9000);
        send_request(CMD_SAMPLE, 160000, 3100, 2000, 9000);
        send_request(CMD_SAMPLE, 160100, 3050, 2000, 9000);
    endtask

    task automatic apply_setting(input int k);
        tx_gaps = (k != 2);
        rx_stalls = (k != 2);
        case (k)
            0: begin load_settings(4150, 300, 4400, 180, 1, 0, 0); home_mv = 4100; end
            1: begin load_settings(4200, 65535, 131071, 65535, 1, 1, 131071); home_mv = 4200; end
            2: begin load_settings(0, 1000, 0, 0, 1, 1, 1); home_mv = 4000; end
            3: begin load_settings(131071, 0, 4500, 2, 0, 0, 20); home_mv = 4300; end
            4: begin load_settings(4150, 200, 131071, 1, 0, 1, 60); home_mv = 4000; end
            default: begin load_settings(3900, 2000, 4300, 30, 1, 1, 0); home_mv = 3950; end
        endcase
    endtask

    task automatic test_random;
        int               sent;
        int               steps;
        int               v;
        int               ma;
        logic [TIME_W-1:0] t;
        logic [CMD_W-1:0] cmd;
        for (int k = 0; k < 6; k++) begin
            drain_results;
            apply_setting(k);
            sent = 0;
            while (sent < 170) begin
                send_request(CMD_START, $urandom, VOLT_W'($urandom), CURR_W'($urandom),
                             POWER_W'($urandom));
                sent++;
                t = $urandom;
                if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 30000);
                v = home_mv - $urandom_range(0, 300);
                ma = $urandom_range(0, 65535);
                steps = $urandom_range(3, 40);
                repeat (steps) begin
                    case ($urandom_range(0, 19))
                        0: t = t - $urandom_range(1, 5000);
                        1: ;
                        2: t = t + $urandom_range(9999, 10001);
                        3: t = t + $urandom_range(10002, 4000000);
                        default: t = t + $urandom_range(1, 3000);
                    endcase
                    case ($urandom_range(0, 9))
                        0: v = $urandom_range(0, 131071);
                        1: v = $urandom_range(0, 200);
                        default: v = v + $urandom_range(0, 60) - 28;
                    endcase
                    if (v < 0) v = 0;
                    if (v > 131071) v = 131071;
                    if ($urandom_range(0, 7) == 0) ma = $urandom_range(0, 65535);
                    else ma = ma - $urandom_range(0, 2000);
                    if (ma < 0) ma = 0;
                    cmd = CMD_SAMPLE;
                    if ($urandom_range(0, 24) == 0) begin
                        case ($urandom_range(0, 2))
                            0: cmd = CMD_START;
                            1: cmd = CMD_STOP;
                            default: cmd = CMD_RESERVED;
                        endcase
                    end
                    send_request(cmd, t, VOLT_W'(v), CURR_W'(ma), POWER_W'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_request(CMD_STOP, $urandom, VOLT_W'($urandom), CURR_W'($urandom),
                                 POWER_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure;
        logic [TIME_W-1:0] t;
        t = $urandom;
        drain_results;
        tx_gaps = 1'b0;
        hold_off_cycles = 200;
        send_request(CMD_START, '0, '0, '0, '0);
        repeat (24) begin
            t = t + $urandom_range(1, 500);
            send_request(CMD_SAMPLE, t, VOLT_W'($urandom_range(3800, 4300)),
                         CURR_W'($urandom), POWER_W'($urandom));
        end
        drain_results;
    endtask

    task automatic test_full_scale;
        logic [TIME_W-1:0] t;
        drain_results;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        load_settings(131071, 0, 131071, 65535, 1, 0, 0);
        send_request(CMD_START, '0, '0, '0, '0);
        // let time wrap: a backward step skips integration and keeps the run alive
        t = 32'hFFFE_0000;
        repeat (30) begin
            send_request(CMD_SAMPLE, t, VOLT_ONES, 16'hFFFF, 23'h7F_FFFF);
            t = t + 9999;
        end
    endtask

    initial begin : watchdog
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : main_sequence
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_commands;
        test_cccv_termination;
        test_float_stage;
        test_faults;
        test_delta_v;
        test_random;
        test_backpressure;
        test_full_scale;
        drain_results;
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
